@@ hdl/cfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Command frame builder package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package cfb_pkg;

   // Width of every byte that passes through the block.
   localparam int BYTE_W = 8;

   // Fixed overhead added to the payload count to form the length byte.
   localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd3;

   // Controller states: idle, and one for each part of the outgoing frame.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEADER,
      ST_LENGTH,
      ST_COMMAND,
      ST_PARAM,
      ST_PAYLOAD,
      ST_CHECKSUM
   } state_type;

   // Selects which byte the datapath places on the result port.
   typedef enum logic [2:0] {
      SEL_HEADER,
      SEL_LENGTH,
      SEL_COMMAND,
      SEL_PARAM,
      SEL_PAYLOAD,
      SEL_CHECKSUM
   } sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    take;      // a request is accepted this cycle
      logic    emit;      // register a result byte this cycle
      sel_type sel;       // which byte to register
      logic    rd_start;  // start reading the payload store at entry zero
      logic    advance;   // step to the next payload entry
      logic    clear;     // frame done, clear the payload totals
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;        // no payload byte collected
      logic final_byte;   // current payload entry is the final one
   } ctrl_status_type;

endpackage

@@ hdl/cfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Command frame builder controller
// Accepts requests and sequences the emission of one frame, byte by byte.
// ----------------------------------------------------------------------------
module cfb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     req_last,
   input  cfb_pkg::ctrl_status_type status,
   output cfb_pkg::ctrl_cmd_type    cmd,
   output logic                     busy
);
   import cfb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_last) begin
               state_in = ST_HEADER;
            end
         end
         ST_HEADER:  state_in = ST_LENGTH;
         ST_LENGTH:  state_in = ST_COMMAND;
         ST_COMMAND: state_in = ST_PARAM;
         ST_PARAM:   state_in = ST_PAYLOAD;
         ST_PAYLOAD: begin
            if (status.empty || status.final_byte) begin
               state_in = ST_CHECKSUM;
            end
         end
         ST_CHECKSUM: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs to the datapath.
   always_comb begin
      cmd          = '0;
      cmd.sel      = SEL_HEADER;
      busy         = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.take = start;
         end
         ST_HEADER: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_HEADER;
         end
         ST_LENGTH: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_LENGTH;
         end
         ST_COMMAND: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_COMMAND;
         end
         ST_PARAM: begin
            cmd.emit     = 1'b1;
            cmd.sel      = SEL_PARAM;
            cmd.rd_start = 1'b1;
         end
         ST_PAYLOAD: begin
            cmd.emit    = 1'b1;
            cmd.sel     = SEL_PAYLOAD;
            cmd.advance = 1'b1;
         end
         ST_CHECKSUM: begin
            cmd.emit  = 1'b1;
            cmd.sel   = SEL_CHECKSUM;
            cmd.clear = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/cfb_datapath.sv @@
// ----------------------------------------------------------------------------
// Command frame builder datapath
// Payload store, running count and sum, header register and result register.
// ----------------------------------------------------------------------------
module cfb_datapath #(
   parameter int MAX_PAYLOAD = 59
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfb_pkg::ctrl_cmd_type         cmd,
   output cfb_pkg::ctrl_status_type      status,
   input  logic [cfb_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                          req_data_valid,
   input  logic [cfb_pkg::BYTE_W-1:0]    req_command,
   input  logic [cfb_pkg::BYTE_W-1:0]    req_command_param,
   input  logic                          csr_write_enable,
   input  logic [cfb_pkg::BYTE_W-1:0]    csr_write_data,
   output logic                          rsp_strobe,
   output logic [cfb_pkg::BYTE_W-1:0]    rsp_frame_byte,
   output logic                          rsp_frame_end
);
   import cfb_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [BYTE_W-1:0] payload_store [MAX_PAYLOAD];

   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [BYTE_W-1:0] sum_ff,    sum_in;
   logic              ended_ff,  ended_in;
   logic [BYTE_W-1:0] header_ff;
   logic [BYTE_W-1:0] command_ff;
   logic [BYTE_W-1:0] param_ff;
   logic [CNT_W-1:0]  idx_ff,    idx_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              strobe_ff;
   logic [BYTE_W-1:0] byte_ff,   byte_in;
   logic              end_ff;

   logic              store_byte;
   logic [CNT_W-1:0]  idx_next;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] length;
   logic [BYTE_W-1:0] total;

   // A valid nonzero byte is stored while the payload is open and not full.
   assign store_byte = cmd.take && req_data_valid && !ended_ff &&
                       (req_data_byte != '0) && (count_ff < CNT_W'(MAX_PAYLOAD));

   // Next values of the payload totals.
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      ended_in = ended_ff;
      if (cmd.clear) begin
         count_in = '0;
         sum_in   = '0;
         ended_in = 1'b0;
      end else if (cmd.take && req_data_valid && !ended_ff) begin
         if (req_data_byte == '0) begin
            ended_in = 1'b1;
         end else if (store_byte) begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + req_data_byte;
         end
      end
   end

   // Control registers: totals, the header marker and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_ff    <= '0;
         ended_ff  <= 1'b0;
         header_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         ended_ff  <= ended_in;
         strobe_ff <= cmd.emit;
         if (csr_write_enable) begin
            header_ff <= csr_write_data;
         end
      end
   end

   // Command and parameter are held from the accepted request.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         command_ff <= req_command;
         param_ff   <= req_command_param;
      end
   end

   // Payload store write.
   always_ff @(posedge clock) begin
      if (store_byte) begin
         payload_store[count_ff[ADDR_W-1:0]] <= req_data_byte;
      end
   end

   // Read pointer: entry zero is fetched during the parameter byte, ahead of the payload.
   assign idx_next = idx_ff + 1'b1;
   assign rd_en    = cmd.rd_start || (cmd.advance && (idx_next < count_ff));
   assign rd_addr  = cmd.rd_start ? '0 : idx_next[ADDR_W-1:0];

   always_comb begin
      idx_in = idx_ff;
      if (cmd.rd_start) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (rd_en) begin
         rd_data_ff <= payload_store[rd_addr];
      end
   end

   // Status back to the controller.
   assign status.empty      = (count_ff == '0);
   assign status.final_byte = (idx_next >= count_ff);

   // Length byte and checksum.
   assign length = LEN_OVERHEAD + (status.empty ? BYTE_W'(1) : BYTE_W'(count_ff));
   assign total  = length + command_ff + param_ff + sum_ff;

   // Byte selection for the result register.
   always_comb begin
      case (cmd.sel)
         SEL_HEADER:   byte_in = header_ff;
         SEL_LENGTH:   byte_in = length;
         SEL_COMMAND:  byte_in = command_ff;
         SEL_PARAM:    byte_in = param_ff;
         SEL_PAYLOAD:  byte_in = status.empty ? '0 : rd_data_ff;
         SEL_CHECKSUM: byte_in = '0 - total;
         default:      byte_in = '0;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= (cmd.sel == SEL_CHECKSUM);
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_end  = end_ff;

endmodule

@@ hdl/command_frame_builder_unit.sv @@
// Payload requests are taken one per cycle while busy is low.
// A request marked last starts a frame of 5 + max(count, 1) bytes, one per cycle;
// the header byte is strobed once the request has passed the state register and
// the result register, and busy stays high while the controller sequences the frame.
// Synchronous reset clears the payload totals, the header marker and the strobe.
// Results are strobed for one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Command frame builder
// Collects payload bytes and emits a framed command with length and checksum.
// ----------------------------------------------------------------------------
module command_frame_builder_unit #(
   parameter int MAX_PAYLOAD = 59
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [cfb_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_data_valid,
   input  logic                       req_last,
   input  logic [cfb_pkg::BYTE_W-1:0] req_command,
   input  logic [cfb_pkg::BYTE_W-1:0] req_command_param,
   input  logic                       csr_write_enable,
   input  logic [cfb_pkg::BYTE_W-1:0] csr_write_data,
   output logic                       rsp_strobe,
   output logic [cfb_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic                       rsp_frame_end
);
   import cfb_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Frame sequencer.
   cfb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Payload store and result path.
   cfb_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_data_byte     (req_data_byte),
      .req_data_valid    (req_data_valid),
      .req_command       (req_command),
      .req_command_param (req_command_param),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Command frame builder testbench
// Drives payload requests into the frame builder, with a directed table first
// and random frames after it, predicts every frame byte and checks each strobed
// byte against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;

   import cfb_pkg::*;

   localparam int PAYLOAD_CAP   = 59;
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_ITEMS   = 22;
   localparam int PLAN_ROWS     = 18;

   typedef logic [BYTE_W-1:0] octet_type;

   // One expected byte of an outgoing frame.
   typedef struct {
      octet_type value;
      logic      closes;
   } frame_entry_type;

   // One row of the directed table; the length and checksum are hand-typed
   // where the row says so.
   typedef struct packed {
      octet_type data;
      logic      valid;
      logic      last;
      octet_type cmd;
      octet_type param;
      octet_type reps;
      logic      typed;
      octet_type t_len;
      octet_type t_csum;
   } stim_row_type;

   localparam stim_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // Empty frame straight after reset, header marker still zero.
      '{8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 8'd1,  1'b1, 8'h04, 8'hFC},
      // All-ones byte, command and parameter on a single last request.
      '{8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'd1,  1'b1, 8'h04, 8'hFF},
      // One byte, an invalid byte, the ending zero, then bytes to be ignored.
      '{8'h01, 1'b1, 1'b0, 8'hFF, 8'h00, 8'd1,  1'b0, 8'h00, 8'h00},
      '{8'hAA, 1'b0, 1'b0, 8'h00, 8'hFF, 8'd1,  1'b0, 8'h00, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'd1,  1'b0, 8'h00, 8'h00},
      '{8'h55, 1'b1, 1'b0, 8'h00, 8'h00, 8'd1,  1'b0, 8'h00, 8'h00},
      '{8'h77, 1'b1, 1'b1, 8'h80, 8'h01, 8'd1,  1'b1, 8'h04, 8'h7A},
      // A zero byte on the last request leaves the payload empty.
      '{8'h00, 1'b1, 1'b1, 8'h12, 8'h34, 8'd1,  1'b1, 8'h04, 8'hB6},
      // Overfilled payload: the count saturates at the capacity.
      '{8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'd62, 1'b0, 8'h00, 8'h00},
      '{8'h01, 1'b1, 1'b1, 8'h00, 8'h00, 8'd1,  1'b1, 8'h3E, 8'hFD},
      // Last request without a data byte after a short payload.
      '{8'h7F, 1'b1, 1'b0, 8'h00, 8'h00, 8'd2,  1'b0, 8'h00, 8'h00},
      '{8'h00, 1'b0, 1'b1, 8'h5A, 8'hA5, 8'd1,  1'b0, 8'h00, 8'h00},
      // Payload reaches the capacity exactly on the last request.
      '{8'h80, 1'b1, 1'b0, 8'h00, 8'h00, 8'd58, 1'b0, 8'h00, 8'h00},
      '{8'h01, 1'b1, 1'b1, 8'hC3, 8'h3C, 8'd1,  1'b0, 8'h00, 8'h00},
      // Ending zero after the payload is already full.
      '{8'hFE, 1'b1, 1'b0, 8'h00, 8'h00, 8'd60, 1'b0, 8'h00, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'd1,  1'b0, 8'h00, 8'h00},
      '{8'h00, 1'b0, 1'b1, 8'h01, 8'h80, 8'd1,  1'b0, 8'h00, 8'h00},
      // Smallest nonzero byte with the widest parameter.
      '{8'h01, 1'b1, 1'b1, 8'h00, 8'hFF, 8'd1,  1'b1, 8'h04, 8'hFC}
   };

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   octet_type req_data_byte;
   logic      req_data_valid;
   logic      req_last;
   octet_type req_command;
   octet_type req_command_param;
   logic      csr_write_enable;
   octet_type csr_write_data;
   logic      rsp_strobe;
   octet_type rsp_frame_byte;
   logic      rsp_frame_end;

   // Predictor state.
   octet_type payload_bytes [PAYLOAD_CAP];
   int        payload_fill;
   octet_type payload_total;
   logic      payload_closed;
   octet_type header_model;

   frame_entry_type frame_bytes_due [$];
   frame_entry_type due_head;
   frame_entry_type patched;
   int              due_base;

   // Hand-typed length and checksum for the request currently driven.
   logic      hand_on;
   octet_type hand_len;
   octet_type hand_csum;

   int taken_count;
   int fault_count;
   int cycle_count;
   int items_sent;

   command_frame_builder_unit #(
      .MAX_PAYLOAD(PAYLOAD_CAP)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data_byte    (req_data_byte),
      .req_data_valid   (req_data_valid),
      .req_last         (req_last),
      .req_command      (req_command),
      .req_command_param(req_command_param),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Takes one accepted request into the payload and, on the last request,
   // queues the whole frame it produces.
   task automatic frame_predict(input octet_type data, input logic valid, input logic last,
                                input octet_type cmd, input octet_type param);
      octet_type length_byte;
      octet_type check_byte;
      if (valid && !payload_closed) begin
         if (data == 8'h00) begin
            payload_closed = 1'b1;
         end else if (payload_fill < PAYLOAD_CAP) begin
            payload_bytes[payload_fill] = data;
            payload_fill++;
            payload_total = payload_total + data;
         end
      end
      if (last) begin
         length_byte = LEN_OVERHEAD + octet_type'((payload_fill == 0) ? 1 : payload_fill);
         check_byte  = length_byte + cmd + param + payload_total;
         check_byte  = 8'h00 - check_byte;
         frame_bytes_due.push_back('{header_model, 1'b0});
         frame_bytes_due.push_back('{length_byte, 1'b0});
         frame_bytes_due.push_back('{cmd, 1'b0});
         frame_bytes_due.push_back('{param, 1'b0});
         if (payload_fill == 0) begin
            frame_bytes_due.push_back('{8'h00, 1'b0});
         end else begin
            for (int i = 0; i < payload_fill; i++) begin
               frame_bytes_due.push_back('{payload_bytes[i], 1'b0});
            end
         end
         frame_bytes_due.push_back('{check_byte, 1'b1});
         payload_fill   = 0;
         payload_total  = 8'h00;
         payload_closed = 1'b0;
      end
   endtask

   // Sampling at the rising edge: result check, register write, request accept.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset) begin
         if (rsp_strobe) begin
            if (frame_bytes_due.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected frame byte %h end %b", $time, rsp_frame_byte,
                        rsp_frame_end);
            end else begin
               due_head = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== due_head.value) begin
                  fault_count++;
                  $display("%0t: frame_byte expected %h actual %h", $time, due_head.value,
                           rsp_frame_byte);
               end
               if (rsp_frame_end !== due_head.closes) begin
                  fault_count++;
                  $display("%0t: frame_end expected %b actual %b", $time, due_head.closes,
                           rsp_frame_end);
               end
            end
         end
         if (csr_write_enable) begin
            header_model = csr_write_data;
         end
         if (start && !busy) begin
            due_base = frame_bytes_due.size();
            frame_predict(req_data_byte, req_data_valid, req_last, req_command,
                          req_command_param);
            // Where the table gives the length and checksum, those stand instead.
            if (hand_on && req_last) begin
               patched = frame_bytes_due[due_base + 1];
               patched.value = hand_len;
               frame_bytes_due[due_base + 1] = patched;
               patched = frame_bytes_due[frame_bytes_due.size() - 1];
               patched.value = hand_csum;
               frame_bytes_due[frame_bytes_due.size() - 1] = patched;
            end
            taken_count++;
         end
      end
   end

   // Presents one request from the falling edge until it is accepted.
   task automatic send_request(input octet_type data, input logic valid, input logic last,
                               input octet_type cmd, input octet_type param,
                               input logic typed, input octet_type t_len,
                               input octet_type t_csum);
      int seen;
      seen              = taken_count;
      start             = 1'b1;
      req_data_byte     = data;
      req_data_valid    = valid;
      req_last          = last;
      req_command       = cmd;
      req_command_param = param;
      hand_on           = typed;
      hand_len          = t_len;
      hand_csum         = t_csum;
      do @(negedge clock); while (taken_count == seen);
   endtask

   // Holds the sender off for a number of cycles with noise on the fields.
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         start = 1'b0;
         repeat (cycles) begin
            req_data_byte     = octet_type'($urandom_range(0, 255));
            req_data_valid    = 1'($urandom_range(0, 1));
            req_last          = 1'($urandom_range(0, 1));
            req_command       = octet_type'($urandom_range(0, 255));
            req_command_param = octet_type'($urandom_range(0, 255));
            @(negedge clock);
         end
      end
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int gap_cycles(input bit enabled);
      int pick;
      pick = int'($urandom_range(0, 99));
      if (!enabled || pick < 60) begin
         return 0;
      end else if (pick < 92) begin
         return int'($urandom_range(1, 3));
      end
      return int'($urandom_range(8, 30));
   endfunction

   // Waits until every expected byte has come and the block has gone quiet.
   task automatic settle_block;
      start = 1'b0;
      while (frame_bytes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Header marker write while the block is idle.
   task automatic write_marker(input octet_type marker);
      csr_write_enable = 1'b1;
      csr_write_data   = marker;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data   = octet_type'($urandom_range(0, 255));
   endtask

   // One random frame: payload bytes with random content, some invalid or
   // zero bytes among them, then the last request.
   task automatic random_frame;
      int        count;
      bit        gaps;
      octet_type data;
      logic      valid;
      gaps  = ($urandom_range(0, 3) != 0);
      count = ($urandom_range(0, 7) == 0) ? int'($urandom_range(50, 70)) :
                                            int'($urandom_range(0, 8));
      for (int i = 0; i < count; i++) begin
         valid = ($urandom_range(0, 9) != 0);
         data  = octet_type'($urandom_range(1, 255));
         if ($urandom_range(0, 39) == 0) begin
            data = 8'h00;
         end
         if (!valid) begin
            data = octet_type'($urandom_range(0, 255));
         end
         send_request(data, valid, 1'b0, octet_type'($urandom_range(0, 255)),
                      octet_type'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00);
         items_sent++;
         pause_sender(gap_cycles(gaps));
      end
      valid = 1'($urandom_range(0, 1));
      data  = ($urandom_range(0, 5) == 0) ? 8'h00 : octet_type'($urandom_range(0, 255));
      send_request(data, valid, 1'b1, octet_type'($urandom_range(0, 255)),
                   octet_type'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00);
      items_sent++;
      pause_sender(gap_cycles(gaps));
   endtask

   // Reset, the directed table, then random phases under several markers.
   initial begin
      stim_row_type row;
      int           phase_start;
      octet_type    marker;
      reset             = 1'b1;
      start             = 1'b0;
      req_data_byte     = '0;
      req_data_valid    = 1'b0;
      req_last          = 1'b0;
      req_command       = '0;
      req_command_param = '0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      hand_on           = 1'b0;
      hand_len          = '0;
      hand_csum         = '0;
      payload_fill      = 0;
      payload_total     = '0;
      payload_closed    = 1'b0;
      header_model      = '0;
      taken_count       = 0;
      fault_count       = 0;
      cycle_count       = 0;
      items_sent        = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed table, with the header marker still at its reset value.
      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         for (int k = 0; k < row.reps; k++) begin
            send_request(row.data, row.valid, row.last, row.cmd, row.param,
                         row.typed && (k == row.reps - 1), row.t_len, row.t_csum);
            pause_sender(gap_cycles(r[0]));
         end
      end

      // Random phases, each under its own header marker.
      for (int phase = 0; phase < 4; phase++) begin
         settle_block();
         marker = (phase == 0) ? 8'hFF :
                  (phase == 1) ? 8'h00 : octet_type'($urandom_range(1, 254));
         write_marker(marker);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            random_frame();
            // Now and then the sender waits for the whole frame to come out.
            if ($urandom_range(0, 5) == 0) begin
               settle_block();
            end
         end
      end

      settle_block();
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ command_frame_builder_unit.f @@
hdl/cfb_pkg.sv
hdl/cfb_ctrl.sv
hdl/cfb_datapath.sv
hdl/command_frame_builder_unit.sv
dv/testbench.sv
